### rtl/bilinear_2x_upscaler_macros.svh
// Assertion helpers used by the checker file.
`ifndef BILINEAR_2X_UPSCALER_MACROS_SVH
`define BILINEAR_2X_UPSCALER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BL2X_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BL2X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bl2x_pkg.sv
// ----------------------------------------------------------------------------
// bl2x_pkg
// Types, constants and the channel average shared by the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
package bl2x_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int CHANNEL_BITS = 8;

  localparam int XW     = $clog2(MAX_WIDTH);   // source column counter
  localparam int YW     = $clog2(MAX_HEIGHT);  // source row counter
  localparam int DIM_W  = 11;                  // size registers
  localparam int DEST_W = 11;                  // destination coordinates

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(320);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(200);

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = CFG_ADDR_W'(1);

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic              last_of_run;
  } out_item_t;

  // Per-channel floor average.
  function automatic pix_t avg2(pix_t a, pix_t b);
    logic [CHANNEL_BITS:0] sr;
    logic [CHANNEL_BITS:0] sg;
    logic [CHANNEL_BITS:0] sb;
    pix_t r;
    sr = {1'b0, a.red}   + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue}  + {1'b0, b.blue};
    r.red   = sr[CHANNEL_BITS:1];
    r.green = sg[CHANNEL_BITS:1];
    r.blue  = sb[CHANNEL_BITS:1];
    return r;
  endfunction

endpackage

### rtl/bilinear_2x_upscaler.sv
// ----------------------------------------------------------------------------
// bilinear_2x_upscaler
// Streaming 2x bilinear enlargement of an RGB frame with a one-row line store.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order; each one leaves 0, 2, 4, 6, 8 or 12
// destination pixels (4 on average over a frame), tagged with coordinates and
// a last_of_run flag on the final one. A new pixel can be taken every cycle
// while in_stall is low, but the output register hands out one destination
// pixel per cycle while out_stall is low, so the sustained rate is set by
// the result count. A pixel's results wait in stage 1 for the line-store
// read and are then loaded into the output register. The line store
// is read and rewritten at the same column in the accept cycle, so no
// clearing pass runs after reset; a write to either size register restarts
// the frame.
module bilinear_2x_upscaler
  import bl2x_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data
);

  // Configuration and frame position
  logic [DIM_W-1:0] src_width_r;
  logic [DIM_W-1:0] src_height_r;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [XW-1:0]    col_cnt_r;
  logic [YW-1:0]    row_cnt_r;
  logic             cfg_hit;
  logic             at_last_col;
  logic             at_last_row;

  // Stage 1: accepted pixel waiting for its line-store read
  logic             s1_valid_r;
  pix_t             s1_cur_r;
  logic [XW-1:0]    s1_x_r;
  logic [YW-1:0]    s1_y_r;
  logic             s1_last_col_r;
  logic             s1_last_row_r;

  pix_t             held_r;
  pix_t             held_above_r;
  logic [PIX_W-1:0] ram_rd_data;
  pix_t             above;

  // Stage 2: output register walking through the results of one pixel
  logic              s2_valid_r;
  pix_t              s2_ev_r [4];
  pix_t              s2_od_r [4];
  logic [DEST_W-1:0] s2_col_base_r;
  logic [1:0]        s2_col_idx_r;
  logic [1:0]        s2_col_last_r;
  logic [DEST_W-1:0] s2_row_r;
  logic [DEST_W-1:0] s2_row_end_r;
  logic              s2_use_od_r;

  pix_t              ev_nxt [4];
  pix_t              od_nxt [4];
  logic [DEST_W-1:0] col_base_nxt;
  logic [1:0]        col_last_nxt;
  logic [DEST_W-1:0] row_nxt;
  logic [DEST_W-1:0] row_end_nxt;
  logic              has_left;
  logic              has_out;

  logic in_fire;
  logic out_fire;
  logic run_done;
  logic s2_free;
  logic s1_move;
  pix_t cur_pix;
  pix_t out_pix;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_hit = cfg_we && (cfg_addr == REG_SRC_WIDTH || cfg_addr == REG_SRC_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RESET_WIDTH;
      src_height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        REG_SRC_HEIGHT: src_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to 1..max
  always_comb begin
    if (src_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (src_width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = src_width_r;
    end
    if (src_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (src_height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = src_height_r;
    end
  end

  assign at_last_col = (DIM_W'(col_cnt_r) == w_eff - DIM_W'(1));
  assign at_last_row = (DIM_W'(row_cnt_r) == h_eff - DIM_W'(1));

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign out_fire = s2_valid_r && !out_stall;
  assign run_done = (s2_col_idx_r == s2_col_last_r) && (s2_row_r == s2_row_end_r);
  assign s2_free  = !s2_valid_r || (out_fire && run_done);
  assign s1_move  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_fire  = in_valid && !in_stall;

  assign cur_pix.red   = in_data.red;
  assign cur_pix.green = in_data.green;
  assign cur_pix.blue  = in_data.blue;

  // --------------------------------------------------------------------------
  // Accept: position counters, line-store access, stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cfg_hit) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_fire) begin
      if (at_last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= at_last_row ? '0 : row_cnt_r + YW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r      <= cur_pix;
      s1_x_r        <= col_cnt_r;
      s1_y_r        <= row_cnt_r;
      s1_last_col_r <= at_last_col;
      s1_last_row_r <= at_last_row;
    end
  end

  // Read the row above and overwrite it with this pixel in one go
  bl2x_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (col_cnt_r),
    .wr_data (cur_pix),
    .rd_en   (in_fire),
    .rd_addr (col_cnt_r),
    .rd_data (ram_rd_data)
  );

  assign above = pix_t'(ram_rd_data);

  // Left neighbours in this row and the row above
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      held_r       <= '0;
      held_above_r <= '0;
    end else if (s1_move) begin
      held_r       <= s1_cur_r;
      held_above_r <= above;
    end
  end

  // --------------------------------------------------------------------------
  // Result set of the pixel in stage 1
  // --------------------------------------------------------------------------
  always_comb begin
    pix_t ev1;
    pix_t vcol;
    ev1  = avg2(held_r, s1_cur_r);
    vcol = avg2(above, s1_cur_r);
    has_left = (s1_x_r != '0);
    has_out  = has_left || s1_last_col_r;
    if (has_left) begin
      ev_nxt[0]    = held_r;
      ev_nxt[1]    = ev1;
      od_nxt[0]    = avg2(held_above_r, held_r);
      od_nxt[1]    = avg2(avg2(held_above_r, above), ev1);
      col_base_nxt = {s1_x_r, 1'b0} - DEST_W'(2);
      col_last_nxt = s1_last_col_r ? 2'd3 : 2'd1;
    end else begin
      ev_nxt[0]    = s1_cur_r;
      ev_nxt[1]    = s1_cur_r;
      od_nxt[0]    = vcol;
      od_nxt[1]    = vcol;
      col_base_nxt = {s1_x_r, 1'b0};
      col_last_nxt = 2'd1;
    end
    ev_nxt[2] = s1_cur_r;
    ev_nxt[3] = s1_cur_r;
    od_nxt[2] = vcol;
    od_nxt[3] = vcol;
    row_nxt     = (s1_y_r != '0) ? {s1_y_r, 1'b0} - DEST_W'(1) : {s1_y_r, 1'b0};
    row_end_nxt = s1_last_row_r ? {s1_y_r, 1'b1} : {s1_y_r, 1'b0};
  end

  // --------------------------------------------------------------------------
  // Stage 2: output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r   <= 1'b0;
      s2_col_idx_r <= '0;
      s2_use_od_r  <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r   <= has_out;
      s2_col_idx_r <= '0;
      s2_use_od_r  <= (s1_y_r != '0);
    end else if (out_fire) begin
      if (run_done) begin
        s2_valid_r <= 1'b0;
      end else if (s2_col_idx_r == s2_col_last_r) begin
        // next destination row of the same run
        s2_col_idx_r <= '0;
        s2_use_od_r  <= 1'b0;
      end else begin
        s2_col_idx_r <= s2_col_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_ev_r       <= ev_nxt;
      s2_od_r       <= od_nxt;
      s2_col_base_r <= col_base_nxt;
      s2_col_last_r <= col_last_nxt;
      s2_row_r      <= row_nxt;
      s2_row_end_r  <= row_end_nxt;
    end else if (out_fire && !run_done && s2_col_idx_r == s2_col_last_r) begin
      s2_row_r <= s2_row_r + DEST_W'(1);
    end
  end

  assign out_pix   = s2_use_od_r ? s2_od_r[s2_col_idx_r] : s2_ev_r[s2_col_idx_r];
  assign out_valid = s2_valid_r;

  assign out_data.dest_x      = s2_col_base_r + DEST_W'(s2_col_idx_r);
  assign out_data.dest_y      = s2_row_r;
  assign out_data.out_red     = out_pix.red;
  assign out_data.out_green   = out_pix.green;
  assign out_data.out_blue    = out_pix.blue;
  assign out_data.last_of_run = run_done;

endmodule

### rtl/bl2x_ram.sv
// ----------------------------------------------------------------------------
// bl2x_ram
// Simple dual-port RAM, one write and one registered read port. A read and
// a write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bl2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bl2x_checker.sv
// ----------------------------------------------------------------------------
// bl2x_checker
// Port-level checks on the upscaler's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "bilinear_2x_upscaler_macros.svh"

module bl2x_checker
  import bl2x_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic out_fire;

  assign out_fire = out_valid && !out_stall;

  // A stalled result holds
  `BL2X_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_data), "stalled result changed")

  // Runs end on an odd destination column
  `BL2X_ASSERT_NOW(a_last_odd, out_valid && out_data.last_of_run, out_data.dest_x[0],
                   "run ends on even column")

  // A run keeps going until its last result is transferred
  `BL2X_ASSERT_NEXT(a_run_cont, out_fire && !out_data.last_of_run, out_valid, "run broken off")

  // An even column is always followed by its odd partner in the same row
  `BL2X_ASSERT_NEXT(a_pair, out_fire && !out_data.dest_x[0],
                    out_valid && out_data.dest_x == $past(out_data.dest_x) + DEST_W'(1) &&
                    out_data.dest_y == $past(out_data.dest_y), "column pair split")

  // The input only stalls behind a pending result
  `BL2X_ASSERT_NOW(a_in_stall, in_stall, out_valid, "input stalled with no result pending")

endmodule

bind bilinear_2x_upscaler bl2x_checker u_bl2x_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/bilinear_2x_upscaler_test.sv
// ----------------------------------------------------------------------------
// bilinear_2x_upscaler_test
// Self-checking bench for the streaming 2x bilinear upscaler: a queue-fed
// driver and a paced receiver. An in-bench pixel predictor with its own line
// store builds the expected destination pixels, which are compared in order.
// ----------------------------------------------------------------------------
module bilinear_2x_upscaler_test;
  import bl2x_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int LONG_HOLD    = 300;
  localparam int TIMEOUT_NS   = 2_000_000;

  // No register lives at this index; a write must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = CFG_ADDR_W'(3);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [DIM_W-1:0]      cfg_data  = '0;

  bilinear_2x_upscaler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus and expectation stores
  in_item_t  src_pending[$];
  out_item_t dest_expected[$];

  logic in_accepted     = 1'b0;
  logic out_taken       = 1'b0;
  logic calm            = 1'b0;
  logic long_hold_armed = 1'b0;
  logic long_hold_done  = 1'b0;
  int   tx_wait         = 0;
  int   rx_wait         = 0;
  int   mismatch_count  = 0;

  // Predictor state
  pix_t             row_mem [MAX_WIDTH];
  pix_t             left_px;
  pix_t             left_above_px;
  int               col_pos;
  int               row_pos;
  logic [DIM_W-1:0] size_w;
  logic [DIM_W-1:0] size_h;

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic pix_t mean_px(pix_t a, pix_t b);
    logic [8:0] s;
    pix_t       r;
    s = {1'b0, a.red} + {1'b0, b.red};
    r.red = s[8:1];
    s = {1'b0, a.green} + {1'b0, b.green};
    r.green = s[8:1];
    s = {1'b0, a.blue} + {1'b0, b.blue};
    r.blue = s[8:1];
    return r;
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t p;
    logic [7:0] c [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0: c[i] = 8'h00;
        1: c[i] = 8'hff;
        default: c[i] = 8'($urandom_range(0, 255));
      endcase
    end
    p.red   = c[0];
    p.green = c[1];
    p.blue  = c[2];
    return p;
  endfunction

  task automatic restart_frame();
    left_px       = '0;
    left_above_px = '0;
    col_pos       = 0;
    row_pos       = 0;
  endtask

  task automatic push_dest(int col, int row, pix_t p, logic last);
    out_item_t r;
    r.dest_x      = DEST_W'(col);
    r.dest_y      = DEST_W'(row);
    r.out_red     = p.red;
    r.out_green   = p.green;
    r.out_blue    = p.blue;
    r.last_of_run = last;
    dest_expected.push_back(r);
  endtask

  // Expected destination pixels completed by one source pixel.
  task automatic predict_source_pixel(in_item_t d);
    int   w, h, x, y, n, nrows, total, k;
    int   cols [4];
    pix_t ev [4];
    pix_t od [4];
    pix_t cur, above, blend;
    w = clamp_dim(size_w, MAX_WIDTH);
    h = clamp_dim(size_h, MAX_HEIGHT);
    x = (col_pos >= w) ? w - 1 : col_pos;
    y = (row_pos >= h) ? h - 1 : row_pos;
    cur.red   = d.red;
    cur.green = d.green;
    cur.blue  = d.blue;
    above = row_mem[x];
    n = 0;
    if (x > 0) begin
      cols[n] = 2 * x - 2;
      ev[n]   = left_px;
      od[n]   = mean_px(left_above_px, left_px);
      n++;
      cols[n] = 2 * x - 1;
      ev[n]   = mean_px(left_px, cur);
      od[n]   = mean_px(mean_px(left_above_px, above), ev[n]);
      n++;
    end
    if (x == w - 1) begin
      blend = mean_px(above, cur);
      for (int j = 0; j < 2; j++) begin
        cols[n] = 2 * x + j;
        ev[n]   = cur;
        od[n]   = blend;
        n++;
      end
    end
    nrows = 1 + ((y > 0) ? 1 : 0) + ((y == h - 1) ? 1 : 0);
    total = n * nrows;
    k = 0;
    if (y > 0) begin
      for (int i = 0; i < n; i++) begin
        k++;
        push_dest(cols[i], 2 * y - 1, od[i], k == total);
      end
    end
    for (int i = 0; i < n; i++) begin
      k++;
      push_dest(cols[i], 2 * y, ev[i], k == total);
    end
    if (y == h - 1) begin
      for (int i = 0; i < n; i++) begin
        k++;
        push_dest(cols[i], 2 * y + 1, ev[i], k == total);
      end
    end
    row_mem[x]    = cur;
    left_px       = cur;
    left_above_px = above;
    if (x == w - 1) begin
      col_pos = 0;
      row_pos = (y == h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endtask

  // Sample every transfer at the rising edge.
  always @(posedge clk) begin : sample_side
    out_item_t want;
    if (!rst_n) begin
      in_accepted <= 1'b0;
      out_taken   <= 1'b0;
      size_w = RESET_WIDTH;
      size_h = RESET_HEIGHT;
      restart_frame();
    end else begin
      in_accepted <= in_valid && !in_stall;
      out_taken   <= out_valid && !out_stall;
      if (cfg_we) begin
        if (cfg_addr == REG_SRC_WIDTH) begin
          size_w = cfg_data;
          restart_frame();
        end else if (cfg_addr == REG_SRC_HEIGHT) begin
          size_h = cfg_data;
          restart_frame();
        end
      end
      if (in_valid && !in_stall) predict_source_pixel(in_data);
      if (out_valid && !out_stall) begin
        if (dest_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: expected no pixel, got x=%0d y=%0d rgb=%h_%h_%h last=%b",
                   $time, out_data.dest_x, out_data.dest_y, out_data.out_red,
                   out_data.out_green, out_data.out_blue, out_data.last_of_run);
        end else begin
          want = dest_expected.pop_front();
          if (out_data.dest_x !== want.dest_x || out_data.dest_y !== want.dest_y ||
              out_data.out_red !== want.out_red ||
              out_data.out_green !== want.out_green ||
              out_data.out_blue !== want.out_blue ||
              out_data.last_of_run !== want.last_of_run) begin
            mismatch_count++;
            $display("%0t ns: expected x=%0d y=%0d rgb=%h_%h_%h last=%b,",
                     $time, want.dest_x, want.dest_y, want.out_red, want.out_green,
                     want.out_blue, want.last_of_run,
                     " got x=%0d y=%0d rgb=%h_%h_%h last=%b",
                     out_data.dest_x, out_data.dest_y, out_data.out_red,
                     out_data.out_green, out_data.out_blue, out_data.last_of_run);
          end
        end
      end
    end
  end

  // Source side: hold until transferred, then wait the drawn gap.
  always @(negedge clk) begin : drive_side
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (!in_valid || in_accepted) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait  <= tx_wait - 1;
      end else if (src_pending.size() != 0) begin
        in_data  <= src_pending.pop_front();
        in_valid <= 1'b1;
        tx_wait  <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall for a drawn count after each transfer; one long hold.
  always @(negedge clk) begin : accept_side
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (out_taken) begin
      w = pick_gap();
      out_stall <= (w != 0);
      rx_wait   <= (w != 0) ? w - 1 : 0;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else if (long_hold_armed && !long_hold_done) begin
      long_hold_done <= 1'b1;
      out_stall      <= 1'b1;
      rx_wait        <= LONG_HOLD;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Wait for every transfer to finish, then let the pipeline empty.
  task automatic settle();
    @(posedge clk);
    #1;
    while (src_pending.size() != 0 || in_valid || dest_expected.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic push_rgb(logic [23:0] rgb);
    in_item_t p;
    p.red   = rgb[23:16];
    p.green = rgb[15:8];
    p.blue  = rgb[7:0];
    src_pending.push_back(p);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) src_pending.push_back(rand_pixel());
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] wr_w, wr_h;
    int cur_w, cur_h, frame, count, rand_sent;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: first pixel gives nothing, then pairs.
    push_rgb(24'hffffff);
    push_rgb(24'h000000);
    push_rgb(24'h80ff01);
    settle();

    // 3x2 frame plus a wrap into the next frame; floor rounding of ff+00.
    write_reg(REG_SRC_WIDTH, DIM_W'(3));
    write_reg(REG_SRC_HEIGHT, DIM_W'(2));
    @(posedge clk);
    push_rgb(24'hffffff);
    push_rgb(24'h000000);
    push_rgb(24'hff00ff);
    push_rgb(24'h00ff00);
    push_rgb(24'hffffff);
    push_rgb(24'h010101);
    push_rgb(24'h7f8081);
    push_rgb(24'hfefefe);
    push_rgb(24'h000001);
    settle();

    // Single column: each pixel doubled across the row, blended rows between.
    write_reg(REG_SRC_WIDTH, DIM_W'(1));
    write_reg(REG_SRC_HEIGHT, DIM_W'(3));
    @(posedge clk);
    push_rgb(24'hff0000);
    push_rgb(24'h00ff00);
    push_rgb(24'h0000ff);
    settle();

    // Zero sizes act as one.
    write_reg(REG_SRC_WIDTH, '0);
    write_reg(REG_SRC_HEIGHT, '0);
    @(posedge clk);
    push_rgb(24'h123456);
    push_rgb(24'hedcba9);
    settle();

    // Oversized registers clamp to the maximum.
    write_reg(REG_SRC_WIDTH, '1);
    write_reg(REG_SRC_HEIGHT, '1);
    @(posedge clk);
    push_random(4);
    settle();

    // Back-pressure: the receiver holds while the source keeps offering.
    write_reg(REG_SRC_WIDTH, DIM_W'(4));
    write_reg(REG_SRC_HEIGHT, DIM_W'(3));
    @(posedge clk);
    calm = 1'b1;
    long_hold_armed = 1'b1;
    push_random(48);
    settle();
    cur_w = 4;
    cur_h = 3;

    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: wr_w = ($urandom_range(0, 1) == 0) ? DIM_W'(0) : DIM_W'(MAX_WIDTH);
        1: wr_w = '1;
        default: wr_w = DIM_W'($urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 9))
        0: wr_h = DIM_W'(0);
        1: wr_h = '1;
        default: wr_h = DIM_W'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 9))
        7: begin
          write_reg(REG_SRC_WIDTH, wr_w);
          cur_w = clamp_dim(wr_w, MAX_WIDTH);
        end
        8: begin
          write_reg(REG_SRC_HEIGHT, wr_h);
          cur_h = clamp_dim(wr_h, MAX_HEIGHT);
        end
        9: begin
          // Ignored write, then a real one to restart the frame.
          write_reg(REG_SPARE, wr_w);
          write_reg(REG_SRC_HEIGHT, wr_h);
          cur_h = clamp_dim(wr_h, MAX_HEIGHT);
        end
        default: begin
          write_reg(REG_SRC_WIDTH, wr_w);
          write_reg(REG_SRC_HEIGHT, wr_h);
          cur_w = clamp_dim(wr_w, MAX_WIDTH);
          cur_h = clamp_dim(wr_h, MAX_HEIGHT);
        end
      endcase
      frame = cur_w * cur_h;
      // Whole frames most of the time, with a partial frame trailing.
      if (frame <= 24)
        count = frame * $urandom_range(1, 2) + $urandom_range(0, cur_w);
      else
        count = $urandom_range(6, 40);
      @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
      push_random(count);
      rand_sent += count;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
